// ===== hw/rtl/opbe_pkg.sv =====
// Shared types, constants, microcode tables and arithmetic helpers of the polynomial evaluator.
`default_nettype none
package opbe_pkg;

    localparam int ORD_W = 6;
    localparam int TAB_N = 64;

    localparam logic signed [63:0] ONE24 = 64'sh0000_0000_0100_0000;
    localparam logic signed [63:0] ONE40 = 64'sh0000_0100_0000_0000;
    localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

    localparam logic [2:0] MODE_HERMITE   = 3'd0;
    localparam logic [2:0] MODE_LEGENDRE  = 3'd1;
    localparam logic [2:0] MODE_NLEGENDRE = 3'd2;
    localparam logic [2:0] MODE_LAGUERRE  = 3'd3;
    localparam logic [2:0] MODE_JACOBI    = 3'd4;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_ORDER = 2'd1;
    localparam logic [1:0] REG_ALPHA = 2'd2;
    localparam logic [1:0] REG_BETA  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MWAIT,
        ST_DWAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        U_P1_SI, U_P1_LA, U_P1_NL, U_P1_JA,
        U_CO_HE, U_CO_LE, U_CO_LA, U_CO_NL,
        U_J_AA, U_J_BB, U_J_T1, U_J_T2, U_J_T3, U_J_T4,
        U_J_U1, U_J_U2, U_J_V1, U_J_V2,
        U_NUM1, U_NUM2, U_DIV, U_EMIT
    } t_uop;

    typedef struct packed {
        logic             load;
        logic             start_mul;
        logic             start_div;
        logic             apply;
        logic             div_wb;
        logic             emit;
        logic             last;
        t_uop             uop;
        logic [ORD_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic               ovf;
        logic signed [63:0] val;
    } t_sat;

    typedef logic [63:0] t_tab [TAB_N];

    function automatic t_sat sat64(input logic signed [127:0] v);
        t_sat r;
        r.ovf = !((&v[127:63]) || !(|v[127:63]));
        if (r.ovf) begin
            r.val = v[127] ? MIN64 : MAX64;
        end else begin
            r.val = v[63:0];
        end
        return r;
    endfunction

    function automatic longint unsigned sqrt_q24(input longint unsigned m);
        longint unsigned v;
        longint unsigned r;
        longint unsigned bv;
        v  = m << 48;
        r  = 64'd0;
        bv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (bv > v) bv = bv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bv != 64'd0) begin
                if (v >= r + bv) begin
                    v = v - (r + bv);
                    r = (r >> 1) + bv;
                end else begin
                    r = r >> 1;
                end
                bv = bv >> 2;
            end
        end
        if (v > r) r = r + 64'd1;
        return r;
    endfunction

    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned rm;
        q  = 64'd0;
        rm = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rm = (rm << 1) | ((n >> i) & 64'd1);
            q  = q << 1;
            if (rm >= d) begin
                rm = rm - d;
                q  = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic t_tab build_ca2();
        t_tab t;
        longint unsigned sp;
        longint unsigned sm;
        t = '{default: '0};
        for (int k = 2; k < TAB_N; k++) begin
            sp   = sqrt_q24(64'(2 * k + 1));
            sm   = sqrt_q24(64'(2 * k - 1));
            t[k] = (sp * sm + 64'h80_0000) >> 24;
        end
        return t;
    endfunction

    function automatic t_tab build_cb2();
        t_tab t;
        longint unsigned sp;
        longint unsigned dn;
        longint unsigned nm;
        t = '{default: '0};
        for (int k = 2; k < TAB_N; k++) begin
            sp   = sqrt_q24(64'(2 * k + 1));
            dn   = sqrt_q24(64'(2 * k - 3));
            nm   = 64'(k - 1) * sp;
            t[k] = udiv64((nm << 24) + (dn >> 1), dn);
        end
        return t;
    endfunction

    localparam t_tab CA2_TAB = build_ca2();
    localparam t_tab CB2_TAB = build_cb2();
    localparam logic signed [63:0] SQRT3 = 64'(sqrt_q24(64'd3));

    function automatic t_uop uop_first(input logic [2:0] mode, input logic [ORD_W-1:0] k);
        t_uop u;
        if (k == ORD_W'(1)) begin
            case (mode)
                MODE_NLEGENDRE: u = U_P1_NL;
                MODE_LAGUERRE:  u = U_P1_LA;
                MODE_JACOBI:    u = U_P1_JA;
                default:        u = U_P1_SI;
            endcase
        end else begin
            case (mode)
                MODE_LEGENDRE:  u = U_CO_LE;
                MODE_NLEGENDRE: u = U_CO_NL;
                MODE_LAGUERRE:  u = U_CO_LA;
                MODE_JACOBI:    u = U_J_AA;
                default:        u = U_CO_HE;
            endcase
        end
        return u;
    endfunction

    function automatic t_uop uop_next(input t_uop u);
        t_uop n;
        case (u) inside
            U_CO_HE, U_CO_LE, U_CO_LA, U_CO_NL, U_J_V2: n = U_NUM1;
            U_J_AA: n = U_J_BB;
            U_J_BB: n = U_J_T1;
            U_J_T1: n = U_J_T2;
            U_J_T2: n = U_J_T3;
            U_J_T3: n = U_J_T4;
            U_J_T4: n = U_J_U1;
            U_J_U1: n = U_J_U2;
            U_J_U2: n = U_J_V1;
            U_J_V1: n = U_J_V2;
            U_NUM1: n = U_NUM2;
            U_NUM2: n = U_DIV;
            default: n = U_EMIT;
        endcase
        return n;
    endfunction

    function automatic logic uop_has_mul(input t_uop u);
        logic m;
        case (u) inside
            U_P1_NL, U_P1_JA, U_CO_NL, U_J_AA, U_J_BB, U_J_T1, U_J_T2, U_J_T3,
            U_J_T4, U_J_U1, U_J_U2, U_J_V1, U_J_V2, U_NUM1, U_NUM2: m = 1'b1;
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/orthogonal_polynomial_basis_eval.sv =====
// Top level of the orthogonal polynomial evaluator: register file, controller and datapath.
//
// Channel   Dir  Payload                                   Handshake
// s_axis    in   tdata[31:0] point                         tvalid/tready
// m_axis    out  tdata order_index, poly_value; tuser ovf  tvalid/tready, tlast on last order
// apb       in   basis_mode, max_order, alpha, beta        psel/penable/pwrite, pready high
//
// One transaction in yields max_order+1 results (capped at MAX_ORDER+1).
// Order 0 needs no arithmetic; order 1 and each higher order run their microcode, using
// the sequential 64x64 multiplier where the mode needs it and, above order 1, the bit-serial divider.
// Reset is synchronous and active low; the configuration registers return to their reset values.
// A stalled result stays in the output register while the next order is computed.
`default_nettype none
module orthogonal_polynomial_basis_eval #(
    parameter int MAX_ORDER = 15
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [31:0]  i_s_axis_tdata,   // [31:0] point
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [71:0]       o_m_axis_tdata,   // [5:0] order_index, [69:6] poly_value
    output logic              o_m_axis_tuser,   // [0] overflow
    output logic              o_m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import opbe_pkg::*;

    logic [2:0]         r_mode;
    logic [5:0]         r_max_order;
    logic signed [31:0] r_alpha;
    logic signed [31:0] r_beta;
    logic               w_wr;
    logic [5:0]         w_top;
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [5:0]         w_order;
    logic signed [63:0] w_value;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HERMITE;
            r_max_order <= 6'd15;
            r_alpha     <= '0;
            r_beta      <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MODE:  r_mode      <= pwdata[2:0];
                REG_ORDER: r_max_order <= pwdata[5:0];
                REG_ALPHA: r_alpha     <= pwdata;
                REG_BETA:  r_beta      <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = {29'd0, r_mode};
            REG_ORDER: prdata = {26'd0, r_max_order};
            REG_ALPHA: prdata = r_alpha;
            REG_BETA:  prdata = r_beta;
            default:   prdata = '0;
        endcase
    end

    assign w_top = (r_max_order > 6'(MAX_ORDER)) ? 6'(MAX_ORDER) : r_max_order;

    opbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_mode  (r_mode),
        .i_top   (w_top),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    opbe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_point     (i_s_axis_tdata),
        .i_alpha     (r_alpha),
        .i_beta      (r_beta),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_order     (w_order),
        .o_value     (w_value),
        .o_ovf       (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_value, w_order};

endmodule
`default_nettype wire

// ===== hw/rtl/opbe_mul.sv =====
// Sequential signed 64x64 multiplier built from four 32x32 partial products.
`default_nettype none
module opbe_mul (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [63:0]  i_a,
    input  wire logic signed [63:0]  i_b,
    output logic                     o_done,
    output logic signed [127:0]      o_prod
);
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [1:0]   r_cnt;
    logic         r_busy;
    logic         r_fin;
    logic         r_done;
    logic [31:0]  w_ha;
    logic [31:0]  w_hb;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        w_ha = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
        w_hb = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
        w_pp = w_ha * w_hb;
        case (r_cnt)
            2'd0:    w_sh = {64'd0, w_pp};
            2'd3:    w_sh = {w_pp, 64'd0};
            default: w_sh = {32'd0, w_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? 64'(-i_a) : i_a;
            r_mb  <= i_b[63] ? 64'(-i_b) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_sh;
        end
        if (r_fin) begin
            o_prod <= r_neg ? -$signed(r_acc) : $signed(r_acc);
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== hw/rtl/opbe_div.sv =====
// Restoring divider of a signed 128-bit numerator by a signed 64-bit divisor with rounding.
`default_nettype none
module opbe_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [127:0] i_num,
    input  wire logic signed [63:0]  i_den,
    output logic                     o_done,
    output logic signed [63:0]       o_quot,
    output logic                     o_ovf
);
    logic [127:0] r_nq;
    logic [63:0]  r_rem;
    logic [63:0]  r_d;
    logic         r_neg;
    logic [6:0]   r_cnt;
    logic         r_busy;
    logic         r_fin1;
    logic         r_fin2;
    logic         r_done;
    logic [127:0] r_q1;
    logic [63:0]  w_r2;
    logic         w_ge;
    logic         w_fit;

    always_comb begin
        w_r2 = {r_rem[62:0], r_nq[127]};
        w_ge = (w_r2 >= r_d);
        if (r_neg) begin
            w_fit = !(|r_q1[127:64]) && (!r_q1[63] || !(|r_q1[62:0]));
        end else begin
            w_fit = !(|r_q1[127:63]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin1 <= 1'b0;
            r_fin2 <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin1 <= 1'b0;
            r_fin2 <= r_fin1;
            r_done <= r_fin2;
            if (i_start) begin
                if (i_den == 64'sd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_fin1 <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num[127] ? 128'(-i_num) : i_num;
            r_d   <= i_den[63] ? 64'(-i_den) : i_den;
            r_neg <= i_num[127] ^ i_den[63];
            r_rem <= '0;
            if (i_den == 64'sd0) begin
                o_quot <= '0;
                o_ovf  <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_r2 - r_d : w_r2;
            r_nq  <= {r_nq[126:0], w_ge};
        end
        if (r_fin1) begin
            r_q1 <= r_nq + {127'd0, (r_rem >= r_d - r_rem)};
        end
        if (r_fin2) begin
            o_ovf <= !w_fit;
            if (!w_fit) begin
                o_quot <= r_neg ? opbe_pkg::MIN64 : opbe_pkg::MAX64;
            end else begin
                o_quot <= r_neg ? -$signed(r_q1[63:0]) : $signed(r_q1[63:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== hw/rtl/opbe_dp.sv =====
// Datapath: operand selection, coefficient registers, recurrence state and result register.
`default_nettype none
module opbe_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire opbe_pkg::t_cmd      i_cmd,
    output opbe_pkg::t_sts           o_sts,
    input  wire logic signed [31:0]  i_point,
    input  wire logic signed [31:0]  i_alpha,
    input  wire logic signed [31:0]  i_beta,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [5:0]               o_order,
    output logic signed [63:0]       o_value,
    output logic                     o_ovf,
    output logic                     o_last
);
    import opbe_pkg::*;

    logic signed [31:0]  r_x;
    logic signed [63:0]  r_pn;
    logic signed [63:0]  r_p1;
    logic signed [63:0]  r_p2;
    logic signed [63:0]  r_ca;
    logic signed [63:0]  r_cb;
    logic signed [63:0]  r_cc;
    logic signed [63:0]  r_t0;
    logic signed [63:0]  r_t1;
    logic signed [127:0] r_num;
    logic                r_ov;
    logic                r_out_valid;

    logic signed [63:0]  w_x;
    logic signed [63:0]  w_a;
    logic signed [63:0]  w_b;
    logic signed [63:0]  w_s;
    logic signed [63:0]  w_nn;
    logic signed [63:0]  w_t2;
    logic signed [63:0]  w_k21;
    logic signed [39:0]  w_lx;
    logic signed [63:0]  w_op_a;
    logic signed [63:0]  w_op_b;
    logic signed [127:0] w_prod;
    logic signed [127:0] w_dab;
    logic                w_mul_done;
    logic                w_div_done;
    logic signed [63:0]  w_quot;
    logic                w_div_ovf;
    t_sat                w_q24;
    t_sat                w_r8;
    t_sat                w_r9;

    always_comb begin
        w_x   = {{32{r_x[31]}}, r_x};
        w_a   = {{32{i_alpha[31]}}, i_alpha};
        w_b   = {{32{i_beta[31]}}, i_beta};
        w_s   = w_a + w_b;
        w_nn  = {34'd0, i_cmd.k, 24'd0};
        w_t2  = (w_nn <<< 1) + w_s;
        w_k21 = {57'd0, i_cmd.k, 1'b0} - 64'sd1;
        w_lx  = $signed({1'b0, w_k21[6:0]}) * r_x;
        w_dab = {{64{1'b0}}, 64'd0} + (128'(w_a - w_b) <<< 24);
        w_dab = $signed({{64{w_dab[87]}}, w_dab[87:24]}) <<< 24;
        w_q24 = sat64((w_prod + 128'sd8388608) >>> 24);
        w_r8  = sat64((w_prod + 128'sd128) >>> 8);
        w_r9  = sat64((w_prod + w_dab + 128'sd256) >>> 9);
    end

    always_comb begin
        unique case (i_cmd.uop)
            U_P1_NL: begin w_op_a = w_x;                     w_op_b = SQRT3;            end
            U_P1_JA: begin w_op_a = w_x;                     w_op_b = w_s + 2 * ONE24;  end
            U_CO_NL: begin w_op_a = CA2_TAB[i_cmd.k];        w_op_b = w_x;              end
            U_J_AA:  begin w_op_a = w_a;                     w_op_b = w_a;              end
            U_J_BB:  begin w_op_a = w_b;                     w_op_b = w_b;              end
            U_J_T1:  begin w_op_a = w_t2 - ONE24;            w_op_b = r_t0 - r_t1;      end
            U_J_T2:  begin w_op_a = w_t2 - 2 * ONE24;        w_op_b = w_t2 - ONE24;     end
            U_J_T3:  begin w_op_a = r_t0;                    w_op_b = w_t2;             end
            U_J_T4:  begin w_op_a = w_x;                     w_op_b = r_t0;             end
            U_J_U1:  begin w_op_a = w_nn - ONE24 + w_a;      w_op_b = w_nn - ONE24 + w_b; end
            U_J_U2:  begin w_op_a = r_t0;                    w_op_b = w_t2;             end
            U_J_V1:  begin w_op_a = w_nn;                    w_op_b = w_nn + w_s;       end
            U_J_V2:  begin w_op_a = r_t0;                    w_op_b = w_t2 - 2 * ONE24; end
            U_NUM1:  begin w_op_a = r_ca;                    w_op_b = r_p1;             end
            U_NUM2:  begin w_op_a = r_cb;                    w_op_b = r_p2;             end
            default: begin w_op_a = r_ca;                    w_op_b = r_p1;             end
        endcase
    end

    opbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_mul),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    opbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (r_num),
        .i_den   (r_cc),
        .o_done  (w_div_done),
        .o_quot  (w_quot),
        .o_ovf   (w_div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_point;
            r_pn <= ONE40;
            r_p1 <= ONE40;
            r_ov <= 1'b0;
        end
        if (i_cmd.apply) begin
            unique case (i_cmd.uop)
                U_P1_SI: r_pn <= w_x <<< 16;
                U_P1_LA: r_pn <= (w_a + ONE24 - w_x) <<< 16;
                U_P1_NL: begin r_pn <= w_r8.val; r_ov <= r_ov | w_r8.ovf; end
                U_P1_JA: begin r_pn <= w_r9.val; r_ov <= r_ov | w_r9.ovf; end
                U_CO_HE: begin
                    r_ca <= w_x;
                    r_cb <= w_nn - ONE24;
                    r_cc <= ONE24;
                end
                U_CO_LE: begin
                    r_ca <= {{24{w_lx[39]}}, w_lx};
                    r_cb <= w_nn - ONE24;
                    r_cc <= w_nn;
                end
                U_CO_LA: begin
                    r_ca <= (w_k21 <<< 24) + w_a - w_x;
                    r_cb <= w_nn - ONE24 + w_a;
                    r_cc <= w_nn;
                end
                U_CO_NL: begin
                    r_ca <= w_q24.val;
                    r_cb <= CB2_TAB[i_cmd.k];
                    r_cc <= w_nn;
                    r_ov <= r_ov | w_q24.ovf;
                end
                U_J_AA, U_J_T2, U_J_T3, U_J_U1, U_J_V1: begin
                    r_t0 <= w_q24.val;
                    r_ov <= r_ov | w_q24.ovf;
                end
                U_J_BB: begin r_t1 <= w_q24.val; r_ov <= r_ov | w_q24.ovf; end
                U_J_T1: begin r_ca <= w_q24.val; r_ov <= r_ov | w_q24.ovf; end
                U_J_T4: begin r_ca <= r_ca + w_q24.val; r_ov <= r_ov | w_q24.ovf; end
                U_J_U2: begin r_cb <= w_q24.val <<< 1; r_ov <= r_ov | w_q24.ovf; end
                U_J_V2: begin r_cc <= w_q24.val <<< 1; r_ov <= r_ov | w_q24.ovf; end
                U_NUM1:  r_num <= w_prod;
                U_NUM2:  r_num <= r_num - w_prod;
                default: ;
            endcase
        end
        if (i_cmd.div_wb) begin
            r_pn <= w_quot;
            r_ov <= r_ov | w_div_ovf;
        end
        if (i_cmd.emit) begin
            r_p2    <= r_p1;
            r_p1    <= r_pn;
            o_order <= i_cmd.k;
            o_value <= r_pn;
            o_ovf   <= r_ov;
            o_last  <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.mul_done = w_mul_done;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/opbe_ctrl.sv =====
// Controller state machine that sequences the per-order microcode of the evaluator.
`default_nettype none
module opbe_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_ready,
    input  wire logic [2:0]          i_mode,
    input  wire logic [5:0]          i_top,
    input  wire opbe_pkg::t_sts      i_sts,
    output opbe_pkg::t_cmd           o_cmd
);
    import opbe_pkg::*;

    t_state           r_state;
    t_state           n_state;
    t_uop             r_uop;
    t_uop             n_uop;
    logic [ORD_W-1:0] r_k;
    logic [ORD_W-1:0] n_k;
    logic [ORD_W-1:0] r_top;
    logic [ORD_W-1:0] n_top;
    logic             w_marker;

    assign w_marker = (r_uop == U_DIV) || (r_uop == U_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_uop   <= U_EMIT;
            r_k     <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_uop   <= n_uop;
            r_k     <= n_k;
            r_top   <= n_top;
        end
    end

    always_comb begin
        n_state = r_state;
        n_uop   = r_uop;
        n_k     = r_k;
        n_top   = r_top;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EMIT;
                    n_k     = '0;
                    n_top   = i_top;
                end
            end
            ST_EXEC: begin
                if (r_uop == U_DIV) begin
                    n_state = ST_DWAIT;
                end else if (r_uop == U_EMIT) begin
                    n_state = ST_EMIT;
                end else if (uop_has_mul(r_uop)) begin
                    n_state = ST_MWAIT;
                end else begin
                    n_uop = uop_next(r_uop);
                end
            end
            ST_MWAIT: begin
                if (i_sts.mul_done) begin
                    n_state = ST_EXEC;
                    n_uop   = uop_next(r_uop);
                end
            end
            ST_DWAIT: begin
                if (i_sts.div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    if (r_k == r_top) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EXEC;
                        n_k     = r_k + ORD_W'(1);
                        n_uop   = uop_first(i_mode, r_k + ORD_W'(1));
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready         = (r_state == ST_IDLE);
        o_cmd.load      = (r_state == ST_IDLE) && i_start;
        o_cmd.start_mul = (r_state == ST_EXEC) && !w_marker && uop_has_mul(r_uop);
        o_cmd.start_div = (r_state == ST_EXEC) && (r_uop == U_DIV);
        o_cmd.apply     = ((r_state == ST_EXEC) && !w_marker && !uop_has_mul(r_uop))
                       || ((r_state == ST_MWAIT) && i_sts.mul_done);
        o_cmd.div_wb    = (r_state == ST_DWAIT) && i_sts.div_done;
        o_cmd.emit      = (r_state == ST_EMIT) && i_sts.out_free;
        o_cmd.last      = (r_k == r_top);
        o_cmd.uop       = r_uop;
        o_cmd.k         = r_k;
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result written while the output register is occupied");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_EMIT && r_k == '0)
        else $error("accepted transaction did not start at order zero");

    a_order_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_k <= r_top)
        else $error("order counter ran past the highest order");

    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_mul |=> r_state == ST_MWAIT)
        else $error("multiplier started without waiting for its result");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench of the orthogonal polynomial evaluator with a built-in recurrence predictor.
`timescale 1ns / 1ps
module tb;
    import opbe_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [5:0]         order_index;
        logic signed [63:0] poly_value;
        logic               overflow;
        logic               last;
    } t_poly_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [31:0] s_point;
    logic        m_ready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [71:0]  o_m_axis_tdata;
    wire         o_m_axis_tuser;
    wire         o_m_axis_tlast;
    wire [31:0]  prdata;
    wire         pready;

    orthogonal_polynomial_basis_eval #(.MAX_ORDER(15)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_point),            // [31:0] point
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(o_m_axis_tdata),     // [5:0] order_index, [69:6] poly_value
        .o_m_axis_tuser(o_m_axis_tuser),     // [0] overflow
        .o_m_axis_tlast(o_m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    logic [2:0]   cfg_mode;
    logic [5:0]   cfg_order;
    longint       cfg_alpha;
    longint       cfg_beta;
    bit           sat_flag;
    t_poly_result poly_expected[$];
    int           err_count;
    int           snd_idle_pct;
    int           rcv_idle_pct;
    int           hold_request;
    int           hold_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp64(input t_wide v);
        if (&v[127:63] || !(|v[127:63])) return v[63:0];
        sat_flag = 1'b1;
        return v[127] ? MIN64 : MAX64;
    endfunction

    function automatic t_wide wide_mul(input longint a, input longint b);
        return t_wide'(a) * t_wide'(b);
    endfunction

    function automatic t_wide shift_round(input t_wide v, input int sh);
        t_wide t;
        t = v + (t_wide'(1) <<< (sh - 1));
        return t >>> sh;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return clamp64(shift_round(wide_mul(a, b), 24));
    endfunction

    function automatic longint fix_div(input t_wide num, input longint den);
        logic [127:0] n;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] d;
        bit           neg;
        if (den == 0) begin
            sat_flag = 1'b1;
            return 0;
        end
        neg = num[127] ^ den[63];
        n = num[127] ? -num : num;
        d = {64'd0, (den < 0) ? 64'(-den) : 64'(den)};
        q = n / d;
        r = n % d;
        if (r >= d - r) q = q + 1;
        if (neg) q = -q;
        return clamp64(q);
    endfunction

    function automatic longint root_fix(input int m);
        longint unsigned v;
        longint unsigned r;
        longint unsigned t;
        v = longint'(m) << 48;
        r = 0;
        for (int b = 28; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        if (v - r * r > r) r = r + 1;
        return r;
    endfunction

    task automatic predict_point(input logic [31:0] xi);
        longint       x;
        longint       a;
        longint       b;
        longint       s;
        longint       p1;
        longint       p2;
        longint       pn;
        longint       nn;
        longint       ca;
        longint       cb;
        longint       cc;
        longint       t2;
        longint       sp;
        longint unsigned numc;
        longint unsigned den;
        logic [2:0]   mode;
        int           top;
        t_poly_result res;
        x = longint'($signed(xi));
        a = cfg_alpha;
        b = cfg_beta;
        s = a + b;
        mode = (cfg_mode > MODE_JACOBI) ? MODE_HERMITE : cfg_mode;
        top = (cfg_order > 15) ? 15 : cfg_order;
        sat_flag = 1'b0;
        p2 = ONE40;
        p1 = 0;
        for (int k = 0; k <= top; k++) begin
            if (k == 0) begin
                pn = ONE40;
            end else if (k == 1) begin
                if (mode == MODE_NLEGENDRE)
                    pn = clamp64(shift_round(wide_mul(x, root_fix(3)), 8));
                else if (mode == MODE_LAGUERRE)
                    pn = (a + ONE24 - x) * 65536;
                else if (mode == MODE_JACOBI)
                    pn = clamp64(shift_round(wide_mul(x, s + 2 * ONE24)
                                             + wide_mul(a - b, ONE24), 9));
                else
                    pn = x * 65536;
            end else begin
                nn = longint'(k) * ONE24;
                if (mode == MODE_LEGENDRE) begin
                    ca = longint'(2 * k - 1) * x;
                    cb = nn - ONE24;
                    cc = nn;
                end else if (mode == MODE_NLEGENDRE) begin
                    sp = root_fix(2 * k + 1);
                    numc = longint'(k - 1) * sp;
                    den = root_fix(2 * k - 3);
                    ca = fix_mul(fix_mul(sp, root_fix(2 * k - 1)), x);
                    cb = ((numc << 24) + den / 2) / den;
                    cc = nn;
                end else if (mode == MODE_LAGUERRE) begin
                    ca = longint'(2 * k - 1) * ONE24 + a - x;
                    cb = nn - ONE24 + a;
                    cc = nn;
                end else if (mode == MODE_JACOBI) begin
                    t2 = 2 * nn + s;
                    ca = fix_mul(t2 - ONE24, fix_mul(a, a) - fix_mul(b, b))
                       + fix_mul(x, fix_mul(fix_mul(t2 - 2 * ONE24, t2 - ONE24), t2));
                    cb = 2 * fix_mul(fix_mul(nn - ONE24 + a, nn - ONE24 + b), t2);
                    cc = 2 * fix_mul(fix_mul(nn, nn + s), t2 - 2 * ONE24);
                end else begin
                    ca = x;
                    cb = nn - ONE24;
                    cc = ONE24;
                end
                pn = fix_div(wide_mul(ca, p1) - wide_mul(cb, p2), cc);
            end
            if (k >= 1) begin
                p2 = p1;
                p1 = pn;
            end else begin
                p1 = pn;
            end
            if (k == 1) p2 = ONE40;
            res.order_index = 6'(k);
            res.poly_value = pn;
            res.overflow = sat_flag;
            res.last = (k == top);
            poly_expected.push_back(res);
        end
    endtask

    // Result checker and receiver-side flow control.
    always @(posedge i_clk) begin
        t_poly_result exp_res;
        if (o_m_axis_tvalid && m_ready) begin
            if (poly_expected.size() == 0) begin
                $display("%0t: unexpected result, actual order %0d value %h", $realtime,
                         o_m_axis_tdata[5:0], o_m_axis_tdata[69:6]);
                err_count++;
            end else begin
                exp_res = poly_expected.pop_front();
                if (o_m_axis_tdata[5:0] !== exp_res.order_index) begin
                    $display("%0t: order_index expected %0d actual %0d", $realtime,
                             exp_res.order_index, o_m_axis_tdata[5:0]);
                    err_count++;
                end
                if (o_m_axis_tdata[69:6] !== exp_res.poly_value) begin
                    $display("%0t: poly_value (order %0d) expected %h actual %h", $realtime,
                             exp_res.order_index, exp_res.poly_value, o_m_axis_tdata[69:6]);
                    err_count++;
                end
                if (o_m_axis_tuser !== exp_res.overflow) begin
                    $display("%0t: overflow (order %0d) expected %b actual %b", $realtime,
                             exp_res.order_index, exp_res.overflow, o_m_axis_tuser);
                    err_count++;
                end
                if (o_m_axis_tlast !== exp_res.last) begin
                    $display("%0t: last (order %0d) expected %b actual %b", $realtime,
                             exp_res.order_index, exp_res.last, o_m_axis_tlast);
                    err_count++;
                end
            end
        end
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MODE:  cfg_mode = value[2:0];
            REG_ORDER: cfg_order = value[5:0];
            REG_ALPHA: cfg_alpha = longint'($signed(value));
            default:   cfg_beta = longint'($signed(value));
        endcase
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (poly_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic setup(input logic [2:0] mode, input logic [5:0] order,
                         input logic [31:0] alpha, input logic [31:0] beta);
        drain_results();
        write_reg(REG_MODE, {29'd0, mode});
        write_reg(REG_ORDER, {26'd0, order});
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_BETA, beta);
    endtask

    task automatic send_point(input logic [31:0] xi);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_point <= xi;
        predict_point(xi);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_point();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h0A00_0000)) - 32'sh0500_0000);
    endfunction

    function automatic logic [31:0] rand_shape();
        if ($urandom_range(7) == 0) return $urandom;
        return 32'($urandom_range(0, 32'h04F0_0000)) - 32'h00F0_0000;
    endfunction

    task automatic test_directed();
        logic [31:0] pts[5];
        pts = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 32'hFF80_0000};
        foreach (pts[i]) send_point(pts[i]);
        for (int m = 1; m <= 4; m++) begin
            setup(3'(m), 6'd6, 32'h0080_0000, 32'h0140_0000);
            send_point(32'h00C0_0000);
            send_point(32'hFE00_0000);
            send_point(32'h7FFF_FFFF);
        end
        setup(3'd7, 6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h0040_0000);
        setup(MODE_JACOBI, 6'd15, 32'h7FFF_FFFF, 32'hFF00_0001);
        send_point(32'h8000_0000);
        setup(MODE_JACOBI, 6'd3, 32'hFF00_0000, 32'hFF00_0000);
        send_point(32'h0080_0000);
        setup(MODE_LAGUERRE, 6'd0, 32'h7FFF_FFFF, 32'h0);
        send_point(32'hFFFF_FFFF);
        setup(3'd5, 6'd2, 32'h0, 32'h0);
        send_point(32'h0120_0000);
        setup(3'd6, 6'd16, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0100_0000);
    endtask

    task automatic test_random(input int groups);
        logic [5:0] order;
        for (int g = 0; g < groups; g++) begin
            order = ($urandom_range(9) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 4));
            setup(3'($urandom_range(0, 7)), order, rand_shape(), rand_shape());
            repeat ($urandom_range(8, 16)) send_point(rand_point());
        end
    endtask

    task automatic test_backpressure();
        setup(MODE_HERMITE, 6'd0, 32'h0, 32'h0);
        snd_idle_pct = 0;
        hold_request = 1500;
        repeat (20) send_point(rand_point());
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_point = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_mode = MODE_HERMITE;
        cfg_order = 6'd15;
        cfg_alpha = 0;
        cfg_beta = 0;
        err_count = 0;
        hold_request = 0;
        hold_left = 0;
        snd_idle_pct = 22;
        rcv_idle_pct = 86;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(12);
        snd_idle_pct = 86;
        rcv_idle_pct = 22;
        test_random(12);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(10);
        test_backpressure();
        drain_results();
        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
